FILE: src/caw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package caw_pkg;

   localparam int unsigned YearMax = 9999;

   typedef struct packed {
      logic [5:0]        now_second;
      logic [5:0]        now_minute;
      logic [4:0]        now_hour;
      logic [4:0]        now_day;
      logic [3:0]        now_month;
      logic [13:0]       now_year;
      logic signed [7:0] delta_second;
      logic signed [7:0] delta_minute;
      logic signed [7:0] delta_hour;
      logic signed [7:0] delta_day;
      logic signed [7:0] delta_month;
      logic signed [7:0] delta_year;
   } req_type;

   typedef struct packed {
      logic [5:0]  new_second;
      logic [5:0]  new_minute;
      logic [4:0]  new_hour;
      logic [4:0]  new_day;
      logic [3:0]  new_month;
      logic [13:0] new_year;
      logic [2:0]  weekday;
   } rsp_type;

   // fields wrapped, day still a raw signed sum, year saturated
   typedef struct packed {
      logic [5:0]        second;
      logic [5:0]        minute;
      logic [4:0]        hour;
      logic signed [8:0] day_sum;
      logic [3:0]        month;
      logic [13:0]       year;
   } adj_type;

   typedef struct packed {
      adj_type    adj;
      logic [6:0] cent;
   } cent_type;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [6:0]  yy;
      logic [1:0]  cent_lo;
      logic        leap;
   } date_type;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [7:0]  key_sum;
   } sum_type;

   localparam logic [2:0] KeyCommon [0:11] = '{
      3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5};
   localparam logic [2:0] KeyLeap [0:11] = '{
      3'd6, 3'd2, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5};
   localparam logic [4:0] MonthLen [0:11] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   // 2^19 / 100 rounded up; exact quotient for any year up to 9999
   localparam logic [12:0] Recip100 = 13'd5243;

   // single wrap: below zero goes to max-1, at or above max goes to 0
   function automatic logic [5:0] wrap_once(input logic signed [8:0] v,
                                            input logic [6:0] max);
      logic signed [8:0] smax;
      logic [5:0]        res;
      smax = $signed({2'b00, max});
      if (v < 0) begin
         res = 6'(max - 7'd1);
      end else if (v >= smax) begin
         res = 6'd0;
      end else begin
         res = v[5:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/caw_adjust.sv
`timescale 1ns / 1ps
`default_nettype none

module caw_adjust (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire caw_pkg::req_type in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output caw_pkg::adj_type     out_data,
   input  wire logic            out_ready
);
   import caw_pkg::*;

   logic              valid_ff;
   adj_type           data_ff;
   adj_type           data_in;
   logic signed [8:0] sec_sum;
   logic signed [8:0] min_sum;
   logic signed [8:0] hour_sum;
   logic signed [8:0] mon_sum;
   logic signed [15:0] year_sum;
   logic [5:0]        hour_w;
   logic [5:0]        mon_w;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sec_sum  = $signed({3'b000, in_data.now_second}) + 9'(in_data.delta_second);
      min_sum  = $signed({3'b000, in_data.now_minute}) + 9'(in_data.delta_minute);
      hour_sum = $signed({4'b0000, in_data.now_hour}) + 9'(in_data.delta_hour);
      mon_sum  = $signed({5'b00000, in_data.now_month}) + 9'(in_data.delta_month);
      year_sum = $signed({2'b00, in_data.now_year}) + 16'(in_data.delta_year);
      hour_w   = wrap_once(hour_sum, 7'd24);
      mon_w    = wrap_once(mon_sum, 7'd12);

      data_in.second  = wrap_once(sec_sum, 7'd60);
      data_in.minute  = wrap_once(min_sum, 7'd60);
      data_in.hour    = hour_w[4:0];
      data_in.month   = mon_w[3:0];
      data_in.day_sum = $signed({4'b0000, in_data.now_day}) + 9'(in_data.delta_day);
      // saturate year to the four-digit range
      if (year_sum < 0) begin
         data_in.year = 14'd0;
      end else if (year_sum > $signed(16'(YearMax))) begin
         data_in.year = 14'(YearMax);
      end else begin
         data_in.year = year_sum[13:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: src/caw_date.sv
`timescale 1ns / 1ps
`default_nettype none

module caw_date (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire caw_pkg::adj_type in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output caw_pkg::date_type     out_data,
   input  wire logic             out_ready
);
   import caw_pkg::*;

   logic        cent_valid_ff;
   cent_type    cent_ff;
   cent_type    cent_in;
   logic        date_valid_ff;
   date_type    date_ff;
   date_type    date_in;
   logic        cent_ready;
   logic        date_ready;
   logic [25:0] prod;
   logic [13:0] hundreds;
   logic [13:0] rem;
   logic        leap;
   logic [4:0]  last_day;

   assign date_ready = !date_valid_ff || out_ready;
   assign cent_ready = !cent_valid_ff || date_ready;
   assign in_ready   = cent_ready;

   // century by reciprocal multiply
   always_comb begin
      prod         = 26'(in_data.year) * 26'(Recip100);
      cent_in.adj  = in_data;
      cent_in.cent = prod[25:19];
   end

   // year within century, leap rule, day fix-up
   always_comb begin
      hundreds = 14'(cent_ff.cent) * 14'd100;
      rem      = cent_ff.adj.year - hundreds;
      if (rem[6:0] == 7'd0) begin
         leap = (cent_ff.cent[1:0] == 2'd0);
      end else begin
         leap = (rem[1:0] == 2'd0);
      end
      last_day = MonthLen[cent_ff.adj.month];
      if (cent_ff.adj.month == 4'd1 && leap) begin
         last_day = last_day + 5'd1;
      end

      date_in.second  = cent_ff.adj.second;
      date_in.minute  = cent_ff.adj.minute;
      date_in.hour    = cent_ff.adj.hour;
      date_in.month   = cent_ff.adj.month;
      date_in.year    = cent_ff.adj.year;
      date_in.yy      = rem[6:0];
      date_in.cent_lo = cent_ff.cent[1:0];
      date_in.leap    = leap;
      if (cent_ff.adj.day_sum <= 0) begin
         date_in.day = last_day;
      end else if (cent_ff.adj.day_sum > $signed({4'b0000, last_day})) begin
         date_in.day = 5'd1;
      end else begin
         date_in.day = cent_ff.adj.day_sum[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cent_valid_ff <= 1'b0;
         date_valid_ff <= 1'b0;
      end else begin
         if (cent_ready) begin
            cent_valid_ff <= in_valid;
         end
         if (date_ready) begin
            date_valid_ff <= cent_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cent_ready && in_valid) begin
         cent_ff <= cent_in;
      end
      if (date_ready && cent_valid_ff) begin
         date_ff <= date_in;
      end
   end

   assign out_valid = date_valid_ff;
   assign out_data  = date_ff;

endmodule

`default_nettype wire

FILE: src/caw_weekday.sv
`timescale 1ns / 1ps
`default_nettype none

module caw_weekday (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire caw_pkg::date_type in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output caw_pkg::rsp_type       out_data,
   input  wire logic              out_ready
);
   import caw_pkg::*;

   logic       sum_valid_ff;
   sum_type    sum_ff;
   sum_type    sum_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       sum_ready;
   logic       rsp_ready;
   logic [2:0] month_key;
   logic [2:0] cent_key;
   logic [6:0] fold1;
   logic [3:0] fold2;
   logic [3:0] fold3;

   assign rsp_ready = !rsp_valid_ff || out_ready;
   assign sum_ready = !sum_valid_ff || rsp_ready;
   assign in_ready  = sum_ready;

   always_comb begin
      month_key = in_data.leap ? KeyLeap[in_data.month] : KeyCommon[in_data.month];
      cent_key  = 3'({2'b11 - in_data.cent_lo, 1'b0});

      sum_in.second  = in_data.second;
      sum_in.minute  = in_data.minute;
      sum_in.hour    = in_data.hour;
      sum_in.day     = in_data.day;
      sum_in.month   = in_data.month;
      sum_in.year    = in_data.year;
      sum_in.key_sum = 8'(in_data.day) + 8'(month_key) + 8'(in_data.yy)
                     + 8'(in_data.yy[6:2]) + 8'(cent_key);
   end

   // mod 7 by folding: 64 and 8 are both 1 mod 7
   always_comb begin
      fold1 = 7'(sum_ff.key_sum[7:6]) + 7'(sum_ff.key_sum[5:0]);
      fold2 = 4'(fold1[6:3]) + 4'(fold1[2:0]);
      fold3 = (fold2 >= 4'd7) ? fold2 - 4'd7 : fold2;

      rsp_in.new_second = sum_ff.second;
      rsp_in.new_minute = sum_ff.minute;
      rsp_in.new_hour   = sum_ff.hour;
      rsp_in.new_day    = sum_ff.day;
      rsp_in.new_month  = sum_ff.month;
      rsp_in.new_year   = sum_ff.year;
      rsp_in.weekday    = (fold3 >= 4'd7) ? 3'(fold3 - 4'd7) : fold3[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (sum_ready) begin
            sum_valid_ff <= in_valid;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && in_valid) begin
         sum_ff <= sum_in;
      end
      if (rsp_ready && sum_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: src/calendar_adjust_weekday.sv
// An accepted request beat reaches its response beat through the registered stages below.
// Throughput: one beat per cycle while rsp_stall is low; stages are field add/wrap, century multiply,
// leap and day fix-up, weekday key sum, and mod-7 reduction.
// A stage holds only while its successor is full and the response is stalled.
// Reset (synchronous, active high) empties every stage; payload is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module calendar_adjust_weekday (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire caw_pkg::req_type  req_data,
   output logic                   req_stall,
   output logic                   rsp_valid,
   output caw_pkg::rsp_type       rsp_data,
   input  wire logic              rsp_stall
);
   import caw_pkg::*;

   logic     adj_valid;
   adj_type  adj_data;
   logic     adj_ready;
   logic     date_valid;
   date_type date_data;
   logic     date_ready;
   logic     req_ready;

   assign req_stall = !req_ready;

   caw_adjust u_adjust (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (req_ready),
      .out_valid (adj_valid),
      .out_data  (adj_data),
      .out_ready (adj_ready)
   );

   caw_date u_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (adj_valid),
      .in_data   (adj_data),
      .in_ready  (adj_ready),
      .out_valid (date_valid),
      .out_data  (date_data),
      .out_ready (date_ready)
   );

   caw_weekday u_weekday (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (date_valid),
      .in_data   (date_data),
      .in_ready  (date_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (!rsp_stall)
   );

   // backpressure reaches the request side only when every stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && adj_valid && date_valid))
      else $error("request stalled with an empty stage");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.new_second < 6'd60 && rsp_data.new_minute < 6'd60
                     && rsp_data.new_hour < 5'd24 && rsp_data.new_month < 4'd12
                     && rsp_data.new_day != 5'd0 && rsp_data.weekday < 3'd7
                     && rsp_data.new_year <= 14'd9999))
      else $error("response field out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire

FILE: tb/sv/calendar_adjust_weekday_tb.sv
`timescale 1ns / 1ps

module calendar_adjust_weekday_tb;
   import caw_pkg::*;

   localparam int DirRows     = 23;
   localparam int RandomItems = 1400;
   localparam int CycleLimit  = 200000;

   localparam int DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int CommonKey   [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
   localparam int LeapKey     [12] = '{6, 2, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

   typedef struct packed {
      req_type stim;
      rsp_type want;
      logic    typed;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req_data;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall;

   rsp_type     pending_times [$];
   dir_row_type dir_rows [DirRows];
   int          error_count  = 0;
   int          beat_count   = 0;
   int          cycle_count  = 0;
   int          stall_left   = 0;
   bit          quiet_stretch = 1'b0;

   calendar_adjust_weekday u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int wrap_field(input int v, input int limit);
      if (v < 0) v = limit - 1;
      if (v >= limit) v = 0;
      return v;
   endfunction

   function automatic rsp_type compute_adjusted_time(input req_type stim);
      int      sec, mins, hr, dd, mon, yr, last, mkey, yy, ckey;
      bit      leap;
      rsp_type res;
      sec  = int'(stim.now_second) + int'($signed(stim.delta_second));
      mins = int'(stim.now_minute) + int'($signed(stim.delta_minute));
      hr   = int'(stim.now_hour)   + int'($signed(stim.delta_hour));
      dd   = int'(stim.now_day)    + int'($signed(stim.delta_day));
      mon  = int'(stim.now_month)  + int'($signed(stim.delta_month));
      yr   = int'(stim.now_year)   + int'($signed(stim.delta_year));
      if (yr < 0) yr = 0;
      if (yr > 9999) yr = 9999;
      sec  = wrap_field(sec, 60);
      mins = wrap_field(mins, 60);
      hr   = wrap_field(hr, 24);
      mon  = wrap_field(mon, 12);
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      last = DaysInMonth[mon] + ((mon == 1 && leap) ? 1 : 0);
      if (dd <= 0) dd = last;
      if (dd > last) dd = 1;
      mkey = leap ? LeapKey[mon] : CommonKey[mon];
      yy   = yr % 100;
      ckey = (3 - (yr / 100) % 4) * 2;
      res.new_second = 6'(sec);
      res.new_minute = 6'(mins);
      res.new_hour   = 5'(hr);
      res.new_day    = 5'(dd);
      res.new_month  = 4'(mon);
      res.new_year   = 14'(yr);
      res.weekday    = 3'((dd + mkey + yy + yy / 4 + ckey) % 7);
      return res;
   endfunction

   function automatic req_type mk_req(input int s, input int mi, input int h, input int d,
                                      input int mo, input int y, input int ds, input int dmi,
                                      input int dh, input int dd, input int dmo, input int dy);
      req_type r;
      r.now_second   = 6'(s);
      r.now_minute   = 6'(mi);
      r.now_hour     = 5'(h);
      r.now_day      = 5'(d);
      r.now_month    = 4'(mo);
      r.now_year     = 14'(y);
      r.delta_second = 8'(ds);
      r.delta_minute = 8'(dmi);
      r.delta_hour   = 8'(dh);
      r.delta_day    = 8'(dd);
      r.delta_month  = 8'(dmo);
      r.delta_year   = 8'(dy);
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input int s, input int mi, input int h, input int d,
                                      input int mo, input int y, input int wd);
      rsp_type r;
      r.new_second = 6'(s);
      r.new_minute = 6'(mi);
      r.new_hour   = 5'(h);
      r.new_day    = 5'(d);
      r.new_month  = 4'(mo);
      r.new_year   = 14'(y);
      r.weekday    = 3'(wd);
      return r;
   endfunction

   // mostly small steps to land on month ends, now and then the full byte
   function automatic logic [7:0] draw_delta();
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom);
      end
      return 8'(int'($urandom_range(0, 8)) - 4);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [13:0] got,
                                input logic [13:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("beat %0d %s got %0d want %0d", beat_count, name, got, want));
      end
   endtask

   task automatic check_adjusted_time(input rsp_type got);
      rsp_type want;
      if (pending_times.size() == 0) begin
         report_mismatch($sformatf("beat %0d arrived with nothing pending", beat_count));
      end else begin
         want = pending_times.pop_front();
         compare_field("new_second", 14'(got.new_second), 14'(want.new_second));
         compare_field("new_minute", 14'(got.new_minute), 14'(want.new_minute));
         compare_field("new_hour", 14'(got.new_hour), 14'(want.new_hour));
         compare_field("new_day", 14'(got.new_day), 14'(want.new_day));
         compare_field("new_month", 14'(got.new_month), 14'(want.new_month));
         compare_field("new_year", got.new_year, want.new_year);
         compare_field("weekday", 14'(got.weekday), 14'(want.weekday));
      end
      beat_count++;
   endtask

   task automatic send_adjustment(input req_type stim, input rsp_type want);
      int gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= stim;
      do @(posedge clock); while (req_stall);
      pending_times.push_back(want);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_times.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_adjusted_time(rsp_data);
         stall_left = quiet_stretch ? 0 : $urandom_range(0, 4);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("calendar_adjust_weekday: mismatch");
         $finish;
      end
   end

   initial begin
      req_type r;
      int      kind;
      bit      raw;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      dir_rows = '{
         '{mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), mk_rsp(0, 0, 0, 31, 0, 0, 1), 1'b1},
         '{mk_req(50, 59, 23, 15, 5, 2024, 20, 1, 1, 0, 0, 0),
           mk_rsp(0, 0, 0, 15, 5, 2024, 6), 1'b1},
         '{mk_req(59, 59, 23, 31, 11, 9999, 0, 0, 0, 0, 0, 127),
           mk_rsp(59, 59, 23, 31, 11, 9999, 5), 1'b1},
         '{mk_req(0, 0, 0, 0, 0, 0, -1, -1, -1, -1, -1, -1),
           mk_rsp(59, 59, 23, 31, 11, 0, 0), 1'b1},
         '{mk_req(0, 0, 0, 29, 1, 2000, 0, 0, 0, 0, 0, 0), mk_rsp(0, 0, 0, 29, 1, 2000, 2), 1'b1},
         '{mk_req(0, 0, 0, 29, 1, 1900, 0, 0, 0, 0, 0, 0), mk_rsp(0, 0, 0, 1, 1, 1900, 4), 1'b1},
         '{mk_req(63, 63, 31, 31, 15, 16383, 0, 0, 0, 0, 0, 0), '0, 1'b0},
         '{mk_req(0, 0, 0, 1, 0, 0, 127, 127, 127, 127, 127, 127), '0, 1'b0},
         '{mk_req(59, 59, 23, 31, 11, 9999, -128, -128, -128, -128, -128, -128), '0, 1'b0},
         '{mk_req(0, 0, 0, 1, 1, 2023, 0, 0, 0, -1, 0, 0), '0, 1'b0},
         '{mk_req(0, 0, 0, 31, 3, 2023, 0, 0, 0, 0, 0, 0), '0, 1'b0},
         '{mk_req(0, 0, 0, 29, 1, 100, 0, 0, 0, 0, 0, -128), '0, 1'b0},
         '{mk_req(0, 0, 0, 1, 0, 9990, 0, 0, 0, 0, 0, 9), '0, 1'b0},
         '{mk_req(0, 0, 0, 1, 0, 9999, 0, 0, 0, 0, 0, 1), '0, 1'b0},
         '{mk_req(0, 0, 0, 31, 0, 2023, 0, 0, 0, 0, 11, 0), '0, 1'b0},
         '{mk_req(0, 0, 0, 31, 11, 2023, 0, 0, 0, 0, 1, 0), '0, 1'b0},
         '{mk_req(0, 0, 0, 0, 0, 2023, 0, 0, 0, 0, 0, 0), '0, 1'b0},
         '{mk_req(0, 0, 23, 15, 15, 2023, 0, 0, 1, 0, -4, 0), '0, 1'b0},
         '{mk_req(59, 0, 0, 15, 0, 2023, -128, 0, 0, 0, 0, 0), '0, 1'b0},
         '{mk_req(0, 0, 0, 29, 1, 2100, 0, 0, 0, 0, 0, 0), '0, 1'b0},
         '{mk_req(0, 0, 0, 29, 1, 2400, 0, 0, 0, 0, 0, 0), '0, 1'b0},
         '{mk_req(42, 21, 21, 10, 10, 10922, 85, -86, 85, -86, 85, -86), '0, 1'b0},
         '{mk_req(21, 42, 10, 21, 5, 5461, -86, 85, -86, 85, -86, 85), '0, 1'b0}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirRows; i++) begin
         send_adjustment(dir_rows[i].stim,
                         dir_rows[i].typed ? dir_rows[i].want
                                           : compute_adjusted_time(dir_rows[i].stim));
      end
      wait_for_idle();

      for (int i = 0; i < RandomItems; i++) begin
         if (i % 350 == 349) wait_for_idle();
         // every fourth stretch of 100 beats draws no request gaps and no response stalls
         quiet_stretch = ((i / 100) % 4 == 3);
         kind = $urandom_range(0, 9);
         raw  = (kind == 0);
         r.now_second = raw ? 6'($urandom) : 6'($urandom_range(0, 59));
         r.now_minute = raw ? 6'($urandom) : 6'($urandom_range(0, 59));
         r.now_hour   = raw ? 5'($urandom) : 5'($urandom_range(0, 23));
         r.now_day    = raw ? 5'($urandom) : 5'($urandom_range(1, 31));
         r.now_month  = raw ? 4'($urandom) : 4'($urandom_range(0, 11));
         case (kind)
            0: r.now_year = 14'($urandom);
            1: r.now_year = 14'($urandom_range(0, 130));
            2: r.now_year = 14'($urandom_range(9870, 9999));
            3: r.now_year = 14'(100 * $urandom_range(0, 99));
            default: r.now_year = 14'($urandom_range(0, 9999));
         endcase
         r.delta_second = draw_delta();
         r.delta_minute = draw_delta();
         r.delta_hour   = draw_delta();
         r.delta_day    = draw_delta();
         r.delta_month  = draw_delta();
         r.delta_year   = draw_delta();
         send_adjustment(r, compute_adjusted_time(r));
      end

      wait_for_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("calendar_adjust_weekday: match");
      end else begin
         $display("calendar_adjust_weekday: mismatch");
      end
      $finish;
   end

endmodule
